>>> rtl/decimal_reading_response_framer_unit_macros.svh
// Assertion helpers shared by the framer modules; they assume clk and arst_n in scope.
`ifndef DECIMAL_READING_RESPONSE_FRAMER_UNIT_MACROS_SVH
`define DECIMAL_READING_RESPONSE_FRAMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define DRRF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define DRRF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define DRRF_ASSERT_IMP(lbl, ante, cons)
`define DRRF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/drrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package drrf_pkg;

	localparam int unsigned DIGITS      = 6;
	localparam int unsigned MAG_W       = 20;
	localparam int unsigned BCD_W       = 4 * DIGITS;
	localparam int unsigned POS_W       = 5;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned RECIP_SHIFT = 23;

	localparam logic [MAG_W-1:0] DIGIT_MAX = 20'd999999;
	localparam logic [MAG_W-1:0] RECIP10   = 20'hCCCCD;

	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_FIVE  = 8'h35;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_X     = 8'h58;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TRAIL = 8'h0F;

	typedef logic [POS_W-1:0] pos_t;

	localparam pos_t POS_HDR_SIX  = 5'd0;
	localparam pos_t POS_HDR_FIVE = 5'd1;
	localparam pos_t POS_HDR_R    = 5'd2;
	localparam pos_t POS_HDR_X    = 5'd3;
	localparam pos_t POS_NODE_H   = 5'd4;
	localparam pos_t POS_NODE_T   = 5'd5;
	localparam pos_t POS_NODE_U   = 5'd6;
	localparam pos_t POS_ZERO     = 5'd7;
	localparam pos_t POS_O        = 5'd8;
	localparam pos_t POS_SIGN     = 5'd9;
	localparam pos_t POS_DIG0     = 5'd10;
	localparam pos_t POS_DIG1     = 5'd11;
	localparam pos_t POS_DIG2     = 5'd12;
	localparam pos_t POS_DIG3     = 5'd13;
	localparam pos_t POS_DIG4     = 5'd14;
	localparam pos_t POS_DIG5     = 5'd15;
	localparam pos_t POS_TRAIL    = 5'd16;
	localparam pos_t POS_SUM      = 5'd17;

	localparam logic [CFG_IDX_W-1:0] CFG_NODE_H = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_T = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_U = 2'd2;

	typedef struct packed {
		logic             neg;
		logic             clamp;
		logic [BCD_W-1:0] bcd;
	} item_t;

	typedef struct packed {
		logic [7:0] hund;
		logic [7:0] tens;
		logic [7:0] units;
	} node_t;

	typedef struct packed {
		logic [MAG_W-1:0] quo;
		logic [3:0]       rem;
	} div10_t;

	function automatic div10_t div10(input logic [MAG_W-1:0] n);
		logic [2*MAG_W-1:0] prod;
		logic [MAG_W-1:0]   q;
		logic [MAG_W-1:0]   r;
		div10_t             res;
		prod = {{MAG_W{1'b0}}, n} * {{MAG_W{1'b0}}, RECIP10};
		q = MAG_W'(prod >> RECIP_SHIFT);
		r = n - ((q << 3) + (q << 1));
		res.quo = q;
		res.rem = r[3:0];
		return res;
	endfunction

endpackage
`default_nettype wire

>>> rtl/decimal_reading_response_framer_unit.sv
// Reading response framer: turns each signed 32-bit reading into an 18-byte ASCII frame.
// Input channel: in_valid / in_stall with the reading; a transaction completes on a rising
// edge with in_valid high and in_stall low. Output channel: out_valid / out_stall with
// frame_byte, last_byte (set on the checksum byte) and clamped (reading beyond six digits).
// Node characters are written through cfg_we / cfg_index / cfg_data; the user must write them
// only while the block is idle, which the block does not enforce. Unused indexes are dropped.
// A reading passes through an eight-stage front pipeline (an input register, sign and clamp,
// then one decimal digit per stage by reciprocal multiply) and a small queue into the byte
// serializer.
// Throughput: the serializer emits one byte per cycle while out_stall is low, and frames
// follow each other with no gap. The front takes a reading every cycle until the
// queue and its pipeline are full, then raises in_stall.
// A stalled output holds its byte; the serializer and then the front pipeline hold behind it.
// Reset clears all valid state and loads node characters '0','0','1'.
`timescale 1ns / 1ps
`default_nettype none
module decimal_reading_response_framer_unit #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [31:0]             reading,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     frame_byte,
	output logic                           last_byte,
	output logic                           clamped,
	input  logic                           cfg_we,
	input  logic [drrf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);
	import drrf_pkg::*;

	node_t node_q;
	item_t push_item;
	item_t rd_item;
	logic  push;
	logic  pop;
	logic  q_full;
	logic  q_nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q.hund  <= CH_ZERO;
			node_q.tens  <= CH_ZERO;
			node_q.units <= CH_ONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NODE_H: node_q.hund  <= cfg_data;
				CFG_NODE_T: node_q.tens  <= cfg_data;
				CFG_NODE_U: node_q.units <= cfg_data;
				default: ;
			endcase
		end
	end

	drrf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.reading   (reading),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	drrf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (push_item),
		.full     (q_full),
		.pop      (pop),
		.rd_item  (rd_item),
		.nonempty (q_nonempty)
	);

	drrf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.node       (node_q),
		.q_nonempty (q_nonempty),
		.q_item     (rd_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.last_byte  (last_byte),
		.clamped    (clamped)
	);

endmodule
`default_nettype wire

>>> rtl/drrf_front.sv
`timescale 1ns / 1ps
`default_nettype none
module drrf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [31:0]    reading,
	input  logic           q_full,
	output logic           push,
	output drrf_pkg::item_t push_item
);
	import drrf_pkg::*;

	logic             adv;
	logic             vld_s1;
	logic [31:0]      raw_s1;
	logic             neg_c;
	logic [31:0]      abs_c;
	logic             clamp_c;
	logic [MAG_W-1:0] mag_c;

	logic             dig_vld_s   [DIGITS+1];
	logic             dig_neg_s   [DIGITS+1];
	logic             dig_clamp_s [DIGITS+1];
	logic [MAG_W-1:0] dig_mag_s   [DIGITS+1];
	logic [BCD_W-1:0] dig_bcd_s   [DIGITS+1];
	div10_t           dv          [DIGITS];

	assign adv      = !(dig_vld_s[DIGITS] && q_full);
	assign in_stall = !adv;

	assign neg_c   = raw_s1[31];
	assign abs_c   = neg_c ? (~raw_s1 + 32'd1) : raw_s1;
	assign clamp_c = abs_c > {{(32-MAG_W){1'b0}}, DIGIT_MAX};
	assign mag_c   = clamp_c ? DIGIT_MAX : abs_c[MAG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			raw_s1         <= reading;
			dig_neg_s[0]   <= neg_c;
			dig_clamp_s[0] <= clamp_c;
			dig_mag_s[0]   <= mag_c;
			dig_bcd_s[0]   <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_vld_s[0] <= 1'b0;
		end else if (adv) begin
			dig_vld_s[0] <= vld_s1;
		end
	end

	for (genvar k = 0; k < DIGITS; k++) begin : g_digit
		assign dv[k] = div10(dig_mag_s[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dig_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				dig_vld_s[k+1] <= dig_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dig_neg_s[k+1]   <= dig_neg_s[k];
				dig_clamp_s[k+1] <= dig_clamp_s[k];
				dig_mag_s[k+1]   <= dv[k].quo;
				dig_bcd_s[k+1]   <= {dv[k].rem, dig_bcd_s[k][BCD_W-1:4]};
			end
		end
	end

	assign push            = dig_vld_s[DIGITS] && !q_full;
	assign push_item.neg   = dig_neg_s[DIGITS];
	assign push_item.clamp = dig_clamp_s[DIGITS];
	assign push_item.bcd   = dig_bcd_s[DIGITS];

endmodule
`default_nettype wire

>>> rtl/drrf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "decimal_reading_response_framer_unit_macros.svh"
module drrf_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  drrf_pkg::item_t wr_item,
	output logic            full,
	input  logic            pop,
	output drrf_pkg::item_t rd_item,
	output logic            nonempty
);
	import drrf_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign full     = count_q == CW'(DEPTH);
	assign nonempty = count_q != '0;
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`DRRF_ASSERT_IMP(a_no_overflow, push, !full || pop)
	`DRRF_ASSERT_IMP(a_no_underflow, pop, count_q != '0)

endmodule
`default_nettype wire

>>> rtl/drrf_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "decimal_reading_response_framer_unit_macros.svh"
module drrf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  drrf_pkg::node_t node,
	input  logic            q_nonempty,
	input  drrf_pkg::item_t q_item,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      frame_byte,
	output logic            last_byte,
	output logic            clamped
);
	import drrf_pkg::*;

	logic       busy_q;
	pos_t       pos_q;
	logic [7:0] sum_q;
	item_t      item_q;
	logic       load;
	logic [7:0] cur_byte;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       clamp_q;

	always_comb begin
		case (pos_q)
			POS_HDR_SIX:  cur_byte = CH_SIX;
			POS_HDR_FIVE: cur_byte = CH_FIVE;
			POS_HDR_R:    cur_byte = CH_R;
			POS_HDR_X:    cur_byte = CH_X;
			POS_NODE_H:   cur_byte = node.hund;
			POS_NODE_T:   cur_byte = node.tens;
			POS_NODE_U:   cur_byte = node.units;
			POS_ZERO:     cur_byte = CH_ZERO;
			POS_O:        cur_byte = CH_O;
			POS_SIGN:     cur_byte = item_q.neg ? CH_MINUS : CH_PLUS;
			POS_DIG0:     cur_byte = CH_ZERO | {4'h0, item_q.bcd[23:20]};
			POS_DIG1:     cur_byte = CH_ZERO | {4'h0, item_q.bcd[19:16]};
			POS_DIG2:     cur_byte = CH_ZERO | {4'h0, item_q.bcd[15:12]};
			POS_DIG3:     cur_byte = CH_ZERO | {4'h0, item_q.bcd[11:8]};
			POS_DIG4:     cur_byte = CH_ZERO | {4'h0, item_q.bcd[7:4]};
			POS_DIG5:     cur_byte = CH_ZERO | {4'h0, item_q.bcd[3:0]};
			POS_TRAIL:    cur_byte = CH_TRAIL;
			POS_SUM:      cur_byte = sum_q;
			default:      cur_byte = 8'h00;
		endcase
	end

	assign load = busy_q && (!out_valid_q || !out_stall);
	assign pop  = q_nonempty && (!busy_q || (load && pos_q == POS_SUM));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= POS_HDR_SIX;
			sum_q  <= 8'h00;
		end else if (pop) begin
			busy_q <= 1'b1;
			pos_q  <= POS_HDR_SIX;
			sum_q  <= 8'h00;
		end else if (load) begin
			if (pos_q == POS_SUM) begin
				busy_q <= 1'b0;
				pos_q  <= POS_HDR_SIX;
			end else begin
				pos_q <= pos_q + pos_t'(1);
				sum_q <= sum_q + cur_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= q_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= cur_byte;
			last_q  <= pos_q == POS_SUM;
			clamp_q <= item_q.clamp;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign last_byte  = last_q;
	assign clamped    = clamp_q;

	`DRRF_ASSERT_IMP(a_pop_at_frame_end, pop, !busy_q || pos_q == POS_SUM)
	`DRRF_ASSERT_NXT(a_sum_ends_frame, load && pos_q == POS_SUM, last_q && (busy_q == $past(pop)))

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import drrf_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int FRAME_BYTES = 18;
	localparam int READING_LIMIT = 999999;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       clamp;
		int         pos;
	} frame_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] reading = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] frame_byte;
	logic last_byte;
	logic clamped;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	logic [7:0] node_hund = CH_ZERO;
	logic [7:0] node_tens = CH_ZERO;
	logic [7:0] node_units = CH_ONE;
	frame_byte_t frame_bytes_due[$];
	int mismatch_count = 0;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	int hold_left = 0;
	int rx_gap_left = 0;

	decimal_reading_response_framer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.reading   (reading),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.frame_byte(frame_byte),
		.last_byte (last_byte),
		.clamped   (clamped),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void queue_response_frame(input logic [31:0] raw);
		logic [7:0] bytes [FRAME_BYTES];
		logic [31:0] mag;
		logic over;
		logic [7:0] sum;
		frame_byte_t fb;
		int i;
		mag = raw[31] ? (32'd0 - raw) : raw;
		over = mag > READING_LIMIT;
		if (over)
			mag = READING_LIMIT;
		bytes[0] = CH_SIX;
		bytes[1] = CH_FIVE;
		bytes[2] = CH_R;
		bytes[3] = CH_X;
		bytes[4] = node_hund;
		bytes[5] = node_tens;
		bytes[6] = node_units;
		bytes[7] = CH_ZERO;
		bytes[8] = CH_O;
		bytes[9] = raw[31] ? CH_MINUS : CH_PLUS;
		for (i = 15; i >= 10; i--) begin
			bytes[i] = CH_ZERO + 8'(mag % 10);
			mag = mag / 10;
		end
		bytes[16] = CH_TRAIL;
		sum = '0;
		for (i = 0; i < 17; i++)
			sum = sum + bytes[i];
		bytes[17] = sum;
		for (i = 0; i < FRAME_BYTES; i++) begin
			fb.data = bytes[i];
			fb.last = (i == FRAME_BYTES - 1);
			fb.clamp = over;
			fb.pos = i;
			frame_bytes_due.push_back(fb);
		end
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(15, 30);
	endfunction

	function automatic logic [31:0] rand_reading();
		int r;
		logic [31:0] mag;
		r = $urandom_range(0, 9);
		if (r <= 3)
			mag = $urandom_range(0, 999);
		else if (r <= 5)
			mag = $urandom_range(0, READING_LIMIT);
		else if (r == 6)
			mag = $urandom_range(READING_LIMIT - 10, READING_LIMIT + 10);
		else
			return $urandom;
		return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (mismatch_count < 40)
			$display("mismatch: %s expected %0h got %0h at %0t", what, want, got, $time);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		frame_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (frame_bytes_due.size() == 0) begin
				report_mismatch("byte with no frame pending", '0, 32'(frame_byte));
			end else begin
				want = frame_bytes_due.pop_front();
				if (frame_byte !== want.data)
					report_mismatch($sformatf("frame_byte pos %0d", want.pos),
						32'(want.data), 32'(frame_byte));
				if (last_byte !== want.last)
					report_mismatch($sformatf("last_byte pos %0d", want.pos),
						32'(want.last), 32'(last_byte));
				if (clamped !== want.clamp)
					report_mismatch($sformatf("clamped pos %0d", want.pos),
						32'(want.clamp), 32'(clamped));
			end
		end
	end

	// hold off for a requested stretch, otherwise stall at random unless rx_idle_en is cleared
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (!rx_idle_en) begin
			out_stall <= 1'b0;
		end else if (rx_gap_left > 0) begin
			out_stall <= 1'b1;
			rx_gap_left = rx_gap_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			rx_gap_left = idle_len() - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_reading(input logic [31:0] value);
		@(negedge clk);
		in_valid <= 1'b1;
		reading <= value;
		do
			@(posedge clk);
		while (in_stall);
		queue_response_frame(value);
	endtask

	task automatic tx_pause(input int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1)
			@(negedge clk);
	endtask

	task automatic send_with_gap(input logic [31:0] value);
		int g;
		send_reading(value);
		g = $urandom_range(0, 9) < 6 ? 0 : idle_len();
		if (tx_idle_en && g > 0)
			tx_pause(g);
	endtask

	task automatic wait_drained();
		while (frame_bytes_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_node(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_NODE_H: node_hund = value;
			CFG_NODE_T: node_tens = value;
			CFG_NODE_U: node_units = value;
			default: ;
		endcase
	endtask

	task automatic test_reset_nodes();
		send_with_gap(32'd0);
		send_with_gap(32'd1);
		send_with_gap(-32'sd1);
		send_with_gap(32'd5);
		tx_pause(1);
	endtask

	task automatic test_reading_extremes();
		send_with_gap(READING_LIMIT);
		send_with_gap(-READING_LIMIT);
		send_with_gap(READING_LIMIT + 1);
		send_with_gap(-(READING_LIMIT + 1));
		send_with_gap(32'h7FFF_FFFF);
		send_with_gap(32'h8000_0000);
		send_with_gap(32'h8000_0001);
		send_with_gap(32'd123456);
		send_with_gap(-32'sd654321);
		send_with_gap(32'd10);
		send_with_gap(32'd100000);
		tx_pause(1);
	endtask

	task automatic test_node_registers();
		write_node(CFG_NODE_H, 8'h00);
		write_node(CFG_NODE_T, 8'hFF);
		write_node(CFG_NODE_U, 8'h80);
		send_with_gap(32'd42);
		send_with_gap(-32'sd987654);
		tx_pause(1);
		write_node(CFG_NODE_H, 8'hFF);
		write_node(CFG_NODE_T, 8'h00);
		write_node(CFG_NODE_U, 8'h7F);
		send_with_gap(32'd777777);
		send_with_gap(32'hFFF0_0000);
		tx_pause(1);
		write_node(CFG_SPARE, 8'h55);
		send_with_gap(32'd31415);
		tx_pause(1);
	endtask

	task automatic test_output_holdoff();
		int i;
		wait_drained();
		tx_idle_en = 1'b0;
		@(posedge clk);
		hold_left = 300;
		for (i = 0; i < 20; i++)
			send_with_gap(rand_reading());
		tx_pause(1);
		wait_drained();
		tx_idle_en = 1'b1;
	endtask

	task automatic test_random_readings();
		int p;
		int i;
		for (p = 0; p < 6; p++) begin
			write_node(CFG_NODE_H, 8'($urandom_range(0, 255)));
			write_node(CFG_NODE_T, 8'($urandom_range(0, 255)));
			write_node(CFG_NODE_U, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 2) == 0)
				write_node(CFG_SPARE, 8'($urandom_range(0, 255)));
			tx_idle_en = (p != 1);
			rx_idle_en = (p != 1);
			for (i = 0; i < 40; i++) begin
				if (p == 3 && i == 20) begin
					tx_pause(1);
					wait_drained();
				end
				send_with_gap(rand_reading());
			end
			tx_pause(1);
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	initial begin
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_nodes();
		test_reading_extremes();
		test_node_registers();
		test_output_holdoff();
		test_random_readings();
		rx_idle_en = 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0 && frame_bytes_due.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/drrf_pkg.sv
rtl/drrf_front.sv
rtl/drrf_queue.sv
rtl/drrf_back.sv
rtl/decimal_reading_response_framer_unit.sv
tb/testbench.sv
